[src/spc_pkg.sv]
// shared types, widths and arithmetic helpers for the segment crossing test
`default_nettype none

package spc_pkg;

    // coordinate width and the widths that grow from it
    localparam int COORD_BITS = 16;
    localparam int DIFF_BITS  = COORD_BITS + 1;
    localparam int PROD_BITS  = 2 * DIFF_BITS;
    localparam int SUM_BITS   = PROD_BITS + 1;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DIFF_BITS-1:0]  t_diff;
    typedef logic signed [PROD_BITS-1:0]  t_wide;
    typedef logic signed [SUM_BITS-1:0]   t_sum;

    // orientation of three points
    typedef enum logic [1:0] {
        ORI_COL = 2'd0,
        ORI_CW  = 2'd1,
        ORI_CCW = 2'd2
    } t_orient;

    // one registered request
    typedef struct packed {
        t_coord query_start_x;
        t_coord query_start_y;
        t_coord query_end_x;
        t_coord query_end_y;
        t_coord edge_start_x;
        t_coord edge_start_y;
        t_coord edge_end_x;
        t_coord edge_end_y;
        logic   last_edge;
    } t_req;

    // registered products of one request
    typedef struct packed {
        logic  valid;
        logic  last;
        logic  shared;
        // orientation terms: p and q for each of the four tests
        t_wide op0;
        t_wide oq0;
        t_wide op1;
        t_wide oq1;
        t_wide op2;
        t_wide oq2;
        t_wide op3;
        t_wide oq3;
        // dot product halves for the four strict-inside tests
        t_wide da0;
        t_wide db0;
        t_wide da1;
        t_wide db1;
        t_wide da2;
        t_wide db2;
        t_wide da3;
        t_wide db3;
        // squared lengths of the edge and the query
        t_wide ea;
        t_wide eb;
        t_wide qa;
        t_wide qb;
    } t_prod;

    // exact difference of two coordinates
    function automatic t_diff f_sub(input t_coord a, input t_coord b);
        f_sub = t_diff'(a) - t_diff'(b);
    endfunction

    // exact product of two differences
    function automatic t_wide f_mul(input t_diff a, input t_diff b);
        f_mul = t_wide'(a) * t_wide'(b);
    endfunction

    // exact sum of two products
    function automatic t_sum f_add(input t_wide a, input t_wide b);
        f_add = t_sum'(a) + t_sum'(b);
    endfunction

endpackage

`default_nettype wire

[src/spc_req_if.sv]
// request channel: query segment, one polygon edge and the last-edge mark
`default_nettype none

interface spc_req_if;
    logic                  valid;
    logic                  ready;
    spc_pkg::t_coord       query_start_x;
    spc_pkg::t_coord       query_start_y;
    spc_pkg::t_coord       query_end_x;
    spc_pkg::t_coord       query_end_y;
    spc_pkg::t_coord       edge_start_x;
    spc_pkg::t_coord       edge_start_y;
    spc_pkg::t_coord       edge_end_x;
    spc_pkg::t_coord       edge_end_y;
    logic                  last_edge;

    modport source (
        output valid, query_start_x, query_start_y, query_end_x, query_end_y,
               edge_start_x, edge_start_y, edge_end_x, edge_end_y, last_edge,
        input  ready
    );

    modport sink (
        input  valid, query_start_x, query_start_y, query_end_x, query_end_y,
               edge_start_x, edge_start_y, edge_end_x, edge_end_y, last_edge,
        output ready
    );
endinterface

`default_nettype wire

[src/spc_res_if.sv]
// result channel: crossing flag for one polygon
`default_nettype none

interface spc_res_if;
    logic valid;
    logic ready;
    logic crosses;

    modport source (
        output valid, crosses,
        input  ready
    );

    modport sink (
        input  valid, crosses,
        output ready
    );
endinterface

`default_nettype wire

[src/spc_prod.sv]
// product stage: differences, products and shared-endpoint check, registered
`default_nettype none

module spc_prod (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_en,
    input  wire logic           i_valid,
    input  wire spc_pkg::t_req  i_req,
    output spc_pkg::t_prod      o_prod
);

    spc_pkg::t_prod r_prod;
    spc_pkg::t_prod n_prod;

    // difference vectors
    spc_pkg::t_diff edx, edy, qdx, qdy;
    spc_pkg::t_diff a0x, a0y, a1x, a1y, a2x, a2y, a3x, a3y;
    spc_pkg::t_diff b0x, b0y, b1x, b1y, b2x, b2y, b3x, b3y;
    logic           shared;

    // segment vectors and point offsets
    always_comb begin
        edx = spc_pkg::f_sub(i_req.edge_end_x, i_req.edge_start_x);
        edy = spc_pkg::f_sub(i_req.edge_end_y, i_req.edge_start_y);
        qdx = spc_pkg::f_sub(i_req.query_end_x, i_req.query_start_x);
        qdy = spc_pkg::f_sub(i_req.query_end_y, i_req.query_start_y);
        // offsets to the far end for the orientation terms
        a0x = spc_pkg::f_sub(i_req.query_start_x, i_req.edge_end_x);
        a0y = spc_pkg::f_sub(i_req.query_start_y, i_req.edge_end_y);
        a1x = spc_pkg::f_sub(i_req.query_end_x, i_req.edge_end_x);
        a1y = spc_pkg::f_sub(i_req.query_end_y, i_req.edge_end_y);
        a2x = spc_pkg::f_sub(i_req.edge_start_x, i_req.query_end_x);
        a2y = spc_pkg::f_sub(i_req.edge_start_y, i_req.query_end_y);
        a3x = spc_pkg::f_sub(i_req.edge_end_x, i_req.query_end_x);
        a3y = spc_pkg::f_sub(i_req.edge_end_y, i_req.query_end_y);
        // offsets from the near end for the dot products
        b0x = spc_pkg::f_sub(i_req.query_start_x, i_req.edge_start_x);
        b0y = spc_pkg::f_sub(i_req.query_start_y, i_req.edge_start_y);
        b1x = spc_pkg::f_sub(i_req.query_end_x, i_req.edge_start_x);
        b1y = spc_pkg::f_sub(i_req.query_end_y, i_req.edge_start_y);
        b2x = spc_pkg::f_sub(i_req.edge_start_x, i_req.query_start_x);
        b2y = spc_pkg::f_sub(i_req.edge_start_y, i_req.query_start_y);
        b3x = spc_pkg::f_sub(i_req.edge_end_x, i_req.query_start_x);
        b3y = spc_pkg::f_sub(i_req.edge_end_y, i_req.query_start_y);
    end

    // any query endpoint on any edge endpoint
    always_comb begin
        shared =
            ((i_req.query_start_x == i_req.edge_end_x) &&
             (i_req.query_start_y == i_req.edge_end_y)) ||
            ((i_req.query_start_x == i_req.edge_start_x) &&
             (i_req.query_start_y == i_req.edge_start_y)) ||
            ((i_req.query_end_x == i_req.edge_end_x) &&
             (i_req.query_end_y == i_req.edge_end_y)) ||
            ((i_req.query_end_x == i_req.edge_start_x) &&
             (i_req.query_end_y == i_req.edge_start_y));
    end

    // products for the next register
    always_comb begin
        n_prod.valid  = i_valid;
        n_prod.last   = i_req.last_edge;
        n_prod.shared = shared;
        n_prod.op0    = spc_pkg::f_mul(edy, a0x);
        n_prod.oq0    = spc_pkg::f_mul(edx, a0y);
        n_prod.op1    = spc_pkg::f_mul(edy, a1x);
        n_prod.oq1    = spc_pkg::f_mul(edx, a1y);
        n_prod.op2    = spc_pkg::f_mul(qdy, a2x);
        n_prod.oq2    = spc_pkg::f_mul(qdx, a2y);
        n_prod.op3    = spc_pkg::f_mul(qdy, a3x);
        n_prod.oq3    = spc_pkg::f_mul(qdx, a3y);
        n_prod.da0    = spc_pkg::f_mul(edx, b0x);
        n_prod.db0    = spc_pkg::f_mul(edy, b0y);
        n_prod.da1    = spc_pkg::f_mul(edx, b1x);
        n_prod.db1    = spc_pkg::f_mul(edy, b1y);
        n_prod.da2    = spc_pkg::f_mul(qdx, b2x);
        n_prod.db2    = spc_pkg::f_mul(qdy, b2y);
        n_prod.da3    = spc_pkg::f_mul(qdx, b3x);
        n_prod.db3    = spc_pkg::f_mul(qdy, b3y);
        n_prod.ea     = spc_pkg::f_mul(edx, edx);
        n_prod.eb     = spc_pkg::f_mul(edy, edy);
        n_prod.qa     = spc_pkg::f_mul(qdx, qdx);
        n_prod.qb     = spc_pkg::f_mul(qdy, qdy);
    end

    // product register, valid bit reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod.valid <= 1'b0;
        end else if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

[src/spc_decide.sv]
// decision logic: orientations, strict-inside tests and the edge hit
`default_nettype none

module spc_decide (
    input  wire spc_pkg::t_prod i_prod,
    output logic                o_hit
);

    spc_pkg::t_orient o0, o1, o2, o3;
    spc_pkg::t_sum    d0, d1, d2, d3, len_e, len_q;
    logic             in0, in1, in2, in3;
    logic             crossing;

    // orientation from the two cross-product terms
    function automatic spc_pkg::t_orient f_orient(input spc_pkg::t_wide p,
                                                  input spc_pkg::t_wide q);
        if (p == q) begin
            f_orient = spc_pkg::ORI_COL;
        end else if (p > q) begin
            f_orient = spc_pkg::ORI_CW;
        end else begin
            f_orient = spc_pkg::ORI_CCW;
        end
    endfunction

    // four orientations
    always_comb begin
        o0 = f_orient(i_prod.op0, i_prod.oq0);
        o1 = f_orient(i_prod.op1, i_prod.oq1);
        o2 = f_orient(i_prod.op2, i_prod.oq2);
        o3 = f_orient(i_prod.op3, i_prod.oq3);
    end

    // dot products and squared lengths
    always_comb begin
        d0    = spc_pkg::f_add(i_prod.da0, i_prod.db0);
        d1    = spc_pkg::f_add(i_prod.da1, i_prod.db1);
        d2    = spc_pkg::f_add(i_prod.da2, i_prod.db2);
        d3    = spc_pkg::f_add(i_prod.da3, i_prod.db3);
        len_e = spc_pkg::f_add(i_prod.ea, i_prod.eb);
        len_q = spc_pkg::f_add(i_prod.qa, i_prod.qb);
    end

    // collinear point strictly between the other segment's ends
    always_comb begin
        in0 = (o0 == spc_pkg::ORI_COL) && (d0 > spc_pkg::t_sum'(0)) && (d0 < len_e);
        in1 = (o1 == spc_pkg::ORI_COL) && (d1 > spc_pkg::t_sum'(0)) && (d1 < len_e);
        in2 = (o2 == spc_pkg::ORI_COL) && (d2 > spc_pkg::t_sum'(0)) && (d2 < len_q);
        in3 = (o3 == spc_pkg::ORI_COL) && (d3 > spc_pkg::t_sum'(0)) && (d3 < len_q);
    end

    // proper crossing, or touching from inside; shared endpoints skip the edge
    always_comb begin
        crossing = (o0 != o1) && (o2 != o3);
        o_hit    = !i_prod.shared && (crossing || in0 || in1 || in2 || in3);
    end

endmodule

`default_nettype wire

[src/segment_polygon_crossing_test_core.sv]
// top level of the segment against polygon crossing test
// Takes one request per cycle while the result is not stalled: a query segment, one polygon
// edge and a last-edge mark. Each edge goes through three register stages (input, products,
// result): the crossing flag for a polygon is registered from the products of its last edge, and
// requests can follow each other every cycle while the pipeline does not hold. The deepest logic
// is the product stage, which holds twenty 17 by 17 bit multipliers working side by side.
// When the result is not taken the whole pipeline holds, and request ready falls in the same
// cycle. Edges with no last-edge mark give no result; their hits are ORed into a sticky flag
// that the last edge reports and clears.
`default_nettype none

module segment_polygon_crossing_test_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    spc_req_if.sink    i_req,
    spc_res_if.source  o_res
);

    logic             en;
    logic             r_s1_valid;
    spc_pkg::t_req    r_req;
    spc_pkg::t_prod   prod;
    logic             hit;
    logic             r_hit_seen;
    logic             r_out_valid;
    logic             r_out_crosses;

    // pipeline moves when the result register is free or being taken
    assign en          = !r_out_valid || o_res.ready;
    assign i_req.ready = en;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_req.query_start_x <= i_req.query_start_x;
            r_req.query_start_y <= i_req.query_start_y;
            r_req.query_end_x   <= i_req.query_end_x;
            r_req.query_end_y   <= i_req.query_end_y;
            r_req.edge_start_x  <= i_req.edge_start_x;
            r_req.edge_start_y  <= i_req.edge_start_y;
            r_req.edge_end_x    <= i_req.edge_end_x;
            r_req.edge_end_y    <= i_req.edge_end_y;
            r_req.last_edge     <= i_req.last_edge;
        end
    end

    // product stage
    spc_prod u_prod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s1_valid),
        .i_req   (r_req),
        .o_prod  (prod)
    );

    // edge hit decision
    spc_decide u_decide (
        .i_prod (prod),
        .o_hit  (hit)
    );

    // sticky hit flag and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_seen  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= prod.valid && prod.last;
            if (prod.valid) begin
                r_hit_seen <= prod.last ? 1'b0 : (r_hit_seen || hit);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_crosses <= r_hit_seen || hit;
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.crosses = r_out_crosses;

    // reset leaves no pending hit and no result
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_hit_seen && !r_out_valid))
        else $error("hit flag or result left set by reset");

    // a reported polygon leaves the flag clear for the next one
    a_flag_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && prod.valid && prod.last) |=> !r_hit_seen)
        else $error("hit flag not cleared after last edge");

    // a stalled result freezes the product stage
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |=> $stable(prod) && $stable(r_hit_seen))
        else $error("pipeline moved while result stalled");

endmodule

`default_nettype wire
